### hdl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, protocol codes and the crc-16 byte step for the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_WRITE_SINGLE = 2'd0,
    REQ_READ_HOLDING = 2'd1,
    REQ_MULTI_HEADER = 2'd2,
    REQ_MULTI_DATA   = 2'd3
  } mrf_req_t;

  // modbus function codes
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

  // crc-16 modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // command queue geometry
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // payload bytes of one command (longest is the write multiple header)
  localparam int CMD_BYTES = 7;
  localparam int CMD_NW    = $clog2(CMD_BYTES + 1);
  // byte position within a command, including the two crc bytes
  localparam int POS_W     = $clog2(CMD_BYTES + 3);

  // one unit of work for the back end
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [CMD_NW-1:0]         nbytes;
    logic                      append_crc;
    logic                      crc_init;
  } mrf_cmd_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Accepts request words, tracks the open write-multiple frame and turns each
// word into a byte command for the back end, or drops it.
// ----------------------------------------------------------------------------
module mrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_slave_id,
  input  logic [15:0]       in_start_reg,
  input  logic [15:0]       in_reg_value,
  input  logic [6:0]        in_reg_count,
  input  logic              q_full,
  output logic              q_push,
  output mrf_pkg::mrf_cmd_t q_cmd
);
  import mrf_pkg::*;

  logic       in_multi_r, in_multi_nxt;
  logic [6:0] words_left_r, words_left_nxt;
  logic       accept;
  logic       drop;
  logic [6:0] words_dec;
  mrf_req_t   req;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign req       = mrf_req_t'(in_func);
  assign words_dec = words_left_r - 7'd1;

  // classify the word and build its command
  always_comb begin
    in_multi_nxt   = in_multi_r;
    words_left_nxt = words_left_r;
    drop           = 1'b0;
    q_cmd          = '0;
    q_cmd.bytes[0] = in_slave_id;
    q_cmd.bytes[2] = in_start_reg[15:8];
    q_cmd.bytes[3] = in_start_reg[7:0];
    q_cmd.crc_init = 1'b1;
    unique case (req)
      REQ_WRITE_SINGLE: begin
        q_cmd.bytes[1]   = FN_WRITE_SINGLE;
        q_cmd.bytes[4]   = in_reg_value[15:8];
        q_cmd.bytes[5]   = in_reg_value[7:0];
        q_cmd.nbytes     = CMD_NW'(6);
        q_cmd.append_crc = 1'b1;
        in_multi_nxt     = 1'b0;
        words_left_nxt   = '0;
      end
      REQ_READ_HOLDING: begin
        q_cmd.bytes[1]   = FN_READ_HOLDING;
        q_cmd.bytes[4]   = 8'h00;
        q_cmd.bytes[5]   = {1'b0, in_reg_count};
        q_cmd.nbytes     = CMD_NW'(6);
        q_cmd.append_crc = 1'b1;
        in_multi_nxt     = 1'b0;
        words_left_nxt   = '0;
      end
      REQ_MULTI_HEADER: begin
        q_cmd.bytes[1] = FN_WRITE_MULTI;
        q_cmd.bytes[4] = 8'h00;
        q_cmd.bytes[5] = {1'b0, in_reg_count};
        q_cmd.bytes[6] = {in_reg_count, 1'b0};
        q_cmd.nbytes   = CMD_NW'(7);
        drop           = (in_reg_count == 7'd0);
        in_multi_nxt   = (in_reg_count != 7'd0);
        words_left_nxt = in_reg_count;
      end
      REQ_MULTI_DATA: begin
        q_cmd.bytes[0]   = in_reg_value[15:8];
        q_cmd.bytes[1]   = in_reg_value[7:0];
        q_cmd.nbytes     = CMD_NW'(2);
        q_cmd.crc_init   = 1'b0;
        q_cmd.append_crc = (words_dec == 7'd0);
        drop             = !in_multi_r;
        if (in_multi_r) begin
          words_left_nxt = words_dec;
          in_multi_nxt   = (words_dec != 7'd0);
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  assign q_push = accept && !drop;

  // frame tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_multi_r   <= 1'b0;
      words_left_r <= '0;
    end else if (accept) begin
      in_multi_r   <= in_multi_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

### hdl/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mrf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrf_pkg::mrf_cmd_t push_cmd,
  input  logic              pop,
  output mrf_pkg::mrf_cmd_t head_cmd,
  output logic              full,
  output logic              empty
);
  import mrf_pkg::*;

  mrf_cmd_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Serializes queued commands one byte a cycle while the output is not stalled, runs the crc and appends it when asked.
// ----------------------------------------------------------------------------
module mrf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mrf_pkg::mrf_cmd_t head_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_tx_byte,
  output logic              out_frame_end
);
  import mrf_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       tx_byte_r, tx_byte_nxt;
  logic             frame_end_r, frame_end_nxt;
  logic             out_ready;
  logic             step;
  logic [15:0]      crc_cur;
  logic [POS_W-1:0] nbytes_ext;
  logic [POS_W-1:0] total;
  logic             is_data;
  logic             is_last;
  logic [7:0]       data_byte;

  assign out_ready  = !out_valid_r || !out_stall;
  assign step       = !q_empty && out_ready;
  assign crc_cur    = (pos_r == '0 && head_cmd.crc_init) ? CRC_INIT : crc_r;
  assign nbytes_ext = POS_W'(head_cmd.nbytes);
  assign total      = nbytes_ext + (head_cmd.append_crc ? POS_W'(2) : POS_W'(0));
  assign is_data    = (pos_r < nbytes_ext);
  assign is_last    = (pos_r == total - POS_W'(1));
  assign data_byte  = head_cmd.bytes[pos_r[CMD_NW-1:0]];
  assign q_pop      = step && is_last;

  // byte sequencer and output register load
  always_comb begin
    crc_nxt       = crc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    tx_byte_nxt   = tx_byte_r;
    frame_end_nxt = frame_end_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      frame_end_nxt = 1'b0;
      pos_nxt       = is_last ? '0 : pos_r + POS_W'(1);
      if (is_data) begin
        tx_byte_nxt = data_byte;
        crc_nxt     = crc_byte(crc_cur, data_byte);
      end else if (pos_r == nbytes_ext) begin
        tx_byte_nxt = crc_cur[7:0];
        crc_nxt     = crc_cur;
      end else begin
        tx_byte_nxt   = crc_cur[15:8];
        crc_nxt       = crc_cur;
        frame_end_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    tx_byte_r   <= tx_byte_nxt;
    frame_end_r <= frame_end_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_frame_end = frame_end_r;

endmodule

### hdl/modbus_rtu_request_framer_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_core
// Modbus RTU master request framer: request words in, frame bytes out.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per request. Write single and read holding
// words give eight bytes (six body bytes, crc low, crc high). A write
// multiple header gives seven bytes and opens a frame; each following data
// word gives its two bytes, and the last one adds the crc. Data words with
// no open frame and headers with a zero count give nothing.
// Output channel (out_*): one byte per word, out_frame_end marks the crc
// high byte that closes a frame.
// The first byte of a word goes through the queue entry and the output register.
// The output gives one byte per cycle while out_stall is low; the back
// end's single byte path with its crc step sets this rate. A two-entry
// command queue lets the input accept while bytes are still going out.
// Reset clears the queue, the open frame and the output valid flag.
// A stall on the output holds the current byte; the queue fills and then
// in_stall rises until the back end moves again.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_slave_id,
  input  logic [15:0] in_start_reg,
  input  logic [15:0] in_reg_value,
  input  logic [6:0]  in_reg_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end
);
  import mrf_pkg::*;

  mrf_cmd_t push_cmd;
  mrf_cmd_t head_cmd;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // request classification
  mrf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_slave_id  (in_slave_id),
    .in_start_reg (in_start_reg),
    .in_reg_value (in_reg_value),
    .in_reg_count (in_reg_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // command queue
  mrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // byte serializer with crc
  mrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
